// File: rtl/url_percent_escape_top_assert.svh
// Assertion macros used by the checker file.
`ifndef URL_PERCENT_ESCAPE_TOP_ASSERT_SVH
`define URL_PERCENT_ESCAPE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define UPE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("upe check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define UPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("upe check failed");

`endif

// File: rtl/upe_pkg.sv
`default_nettype none

package upe_pkg;

  localparam int unsigned MaxResults = 7;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChBslash  = 8'h5C;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] Radix     = 8'd16;

  // Lookahead and URL state carried from one request to the next.
  typedef struct packed {
    logic [1:0] pending_count;
    logic [7:0] pending_digit;
    logic       fragment_seen;
    logic       terminated;
  } st_t;

  // Result bytes produced by one request.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [2:0]                 count;
    logic                       marker;
    logic                       url_end;
  } exp_t;

endpackage

`default_nettype wire

// File: rtl/upe_in_if.sv
`default_nettype none

interface upe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       url_last;

  modport source (output valid, output in_byte, output url_last, input ready);
  modport sink (input valid, input in_byte, input url_last, output ready);
endinterface

`default_nettype wire

// File: rtl/upe_out_if.sv
`default_nettype none

interface upe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       url_end;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output url_end, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input run_last,
                input url_end, output ready);
endinterface

`default_nettype wire

// File: rtl/upe_expand.sv
`default_nettype none

module upe_expand (
  input  upe_pkg::st_t  st_i,
  input  logic [7:0]    in_byte_i,
  input  logic          url_last_i,
  output upe_pkg::exp_t exp_o,
  output upe_pkg::st_t  st_o
);

  // Bit k set means ASCII code k passes through unchanged.
  localparam logic [127:0] Allowed = {16'h47FF, 16'hFFFE, 16'h87FF, 16'hFFFF,
                                      16'hAFFF, 16'hFFD2, 16'h0000, 16'h0000};

  typedef struct packed {
    upe_pkg::exp_t e;
    upe_pkg::st_t  s;
  } work_t;

  function automatic logic is_hex(logic [7:0] b);
    return (b >= upe_pkg::ChZero && b <= upe_pkg::ChZero + 8'd9) ||
           (b >= upe_pkg::ChUpperA && b <= upe_pkg::ChUpperA + 8'd5) ||
           (b >= upe_pkg::ChLowerA && b <= upe_pkg::ChLowerA + 8'd5);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    return (v > 4'd9) ? upe_pkg::ChUpperA + {4'd0, v} - 8'd10 : upe_pkg::ChZero + {4'd0, v};
  endfunction

  function automatic work_t push(work_t w, logic [7:0] b);
    work_t r;
    r = w;
    if (r.e.count != 3'(upe_pkg::MaxResults)) begin
      r.e.bytes[r.e.count] = b;
      r.e.count = r.e.count + 3'd1;
    end
    return r;
  endfunction

  function automatic work_t push_esc(work_t w, logic [7:0] b);
    work_t r;
    r = push(w, upe_pkg::ChPercent);
    r = push(r, hex_char(b[7:4]));
    r = push(r, hex_char(b[3:0]));
    return r;
  endfunction

  function automatic work_t proc(work_t w, logic [7:0] b);
    work_t r;
    r = w;
    if (b == upe_pkg::ChHash && !r.s.fragment_seen) begin
      r = push(r, b);
      r.s.fragment_seen = 1'b1;
    end else if (!b[7] && Allowed[b[6:0]]) begin
      r = push(r, b);
    end else if (b == upe_pkg::ChBslash) begin
      r = push(r, upe_pkg::ChSlash);
    end else if (b == upe_pkg::ChPercent) begin
      r.s.pending_count = 2'd1;
    end else begin
      r = push_esc(r, b);
    end
    return r;
  endfunction

  function automatic work_t flush(work_t w);
    work_t r;
    r = w;
    if (r.s.pending_count >= 2'd1) r = push_esc(r, upe_pkg::ChPercent);
    if (r.s.pending_count >= 2'd2) r = push(r, r.s.pending_digit);
    r.s.pending_count = 2'd0;
    r.s.pending_digit = 8'd0;
    return r;
  endfunction

  work_t w;

  always_comb begin
    w.e = '0;
    w.s = st_i;
    if (st_i.terminated) begin
      // Bytes after an early zero are dropped.
    end else if (in_byte_i == 8'd0) begin
      w = flush(w);
      w.s.terminated = 1'b1;
    end else if (st_i.pending_count == 2'd0) begin
      w = proc(w, in_byte_i);
    end else if (st_i.pending_count == 2'd1) begin
      if (is_hex(in_byte_i)) begin
        w.s.pending_digit = in_byte_i;
        w.s.pending_count = 2'd2;
      end else begin
        w.s.pending_count = 2'd0;
        w = push_esc(w, upe_pkg::ChPercent);
        w = proc(w, in_byte_i);
      end
    end else begin
      if (is_hex(in_byte_i)) begin
        w = push(w, upe_pkg::ChPercent);
        w = push(w, st_i.pending_digit);
        w = push(w, in_byte_i);
      end else begin
        w = push_esc(w, upe_pkg::ChPercent);
        w = push(w, st_i.pending_digit);
      end
      w.s.pending_count = 2'd0;
      w.s.pending_digit = 8'd0;
      if (!is_hex(in_byte_i)) w = proc(w, in_byte_i);
    end

    if (url_last_i) begin
      w = flush(w);
      if (w.e.count == 3'd0) begin
        w.e.marker = 1'b1;
        w.e.count  = 3'd1;
      end
      w.e.url_end = 1'b1;
      w.s = '0;
    end
  end

  assign exp_o = w.e;
  assign st_o  = w.s;

endmodule

`default_nettype wire

// File: rtl/url_percent_escape_top.sv
// The first result of a request is offered once the request has moved from the
// input register (s1) into the result buffer; that move waits for a free buffer.
// Throughput: one result per cycle while out_o.ready is high; a request holds the
// buffer until its results are taken; a request causes zero to seven results.
// Reset (rst_ni low, asynchronous) empties both stages and clears the URL state.
`default_nettype none

module url_percent_escape_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  upe_in_if.sink     in_i,
  upe_out_if.source  out_o
);

  logic                                 s1_valid_q;
  logic [7:0]                           s1_byte_q;
  logic                                 s1_last_q;
  upe_pkg::st_t                         st_q;
  logic [upe_pkg::MaxResults-1:0][7:0]  buf_q;
  logic [2:0]                           cnt_q;
  logic [2:0]                           rd_q;
  logic                                 marker_q;
  logic                                 end_q;

  upe_pkg::exp_t exp;
  upe_pkg::st_t  st_d;
  logic          out_fire;
  logic          at_last;
  logic          buf_free;
  logic          s1_move;

  upe_expand u_expand (
    .st_i       (st_q),
    .in_byte_i  (s1_byte_q),
    .url_last_i (s1_last_q),
    .exp_o      (exp),
    .st_o       (st_d)
  );

  assign at_last  = (rd_q == cnt_q - 3'd1);
  assign out_fire = out_o.valid && out_o.ready;
  assign buf_free = (cnt_q == 3'd0) || (out_fire && at_last);
  assign s1_move  = s1_valid_q && buf_free;
  assign in_i.ready = !s1_valid_q || buf_free;

  assign out_o.valid      = (cnt_q != 3'd0);
  assign out_o.out_byte   = marker_q ? 8'd0 : buf_q[rd_q];
  assign out_o.byte_valid = !marker_q;
  assign out_o.run_last   = at_last;
  assign out_o.url_end    = end_q && at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      st_q       <= '0;
      cnt_q      <= 3'd0;
      rd_q       <= 3'd0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        st_q <= st_d;
      end
      if (s1_move) begin
        // A request that causes no result leaves the buffer empty.
        cnt_q <= exp.count;
        rd_q  <= 3'd0;
      end else if (out_fire) begin
        if (at_last) begin
          cnt_q <= 3'd0;
          rd_q  <= 3'd0;
        end else begin
          rd_q <= rd_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.in_byte;
      s1_last_q <= in_i.url_last;
    end
    if (s1_move) begin
      buf_q    <= exp.bytes;
      marker_q <= exp.marker;
      end_q    <= exp.url_end;
    end
  end

endmodule

`default_nettype wire

// File: rtl/upe_checker.sv
`default_nettype none
`include "url_percent_escape_top_assert.svh"

module upe_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       byte_valid_i,
  input wire logic       run_last_i,
  input wire logic       url_end_i
);

  // An end marker is the single, final result of its URL and carries a zero byte.
  `UPE_ASSERT_NOW(a_marker, out_valid_i && !byte_valid_i, run_last_i && url_end_i && out_byte_i == 8'd0)

  `UPE_ASSERT_NOW(a_end_is_last, out_valid_i && url_end_i, run_last_i)

  // More results of the same request follow directly after a taken non-final one.
  `UPE_ASSERT_NEXT(a_run_continues, out_valid_i && out_ready_i && !run_last_i, out_valid_i)

  `UPE_ASSERT_NEXT(a_stall_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_byte_i) && $stable(run_last_i))

endmodule

bind url_percent_escape_top upe_checker u_upe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_byte_i   (out_o.out_byte),
  .byte_valid_i (out_o.byte_valid),
  .run_last_i   (out_o.run_last),
  .url_end_i    (out_o.url_end)
);

`default_nettype wire
